FILE: design/rbv_pkg.sv
// Package for the rank-by-value unit: widths, controller states and the
// command and status groups between controller and datapath. No dependencies.
package rbv_pkg;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 6;

    typedef enum logic [1:0] {
        S_LOAD,
        S_RANK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic rotate;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic emit_last;
    } t_stat;

endpackage

FILE: design/rbv_datapath.sv
// Datapath of the rank-by-value unit: a row of value/rank cells that rotate
// as a ring to count smaller values, then shift out in arrival order. Uses rbv_pkg.
module rbv_datapath import rbv_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [VALUE_W-1:0] i_value,
    output t_stat              o_stat,
    output logic [RANK_W-1:0]  o_rank,
    output logic               o_overflow
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [VALUE_W-1:0] r_val  [DEPTH];
    logic        [RANK_W-1:0]  r_rank [DEPTH];
    logic                      r_vld  [DEPTH];
    logic        [CNT_W-1:0]   r_cnt;
    logic                      r_ovf;
    logic                      w_inc  [DEPTH];
    logic                      w_room;

    assign w_room = (r_cnt < CNT_W'(DEPTH));

    // cell 0 broadcasts its value; every cell counts broadcasts below its own
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_inc[i] = r_vld[0] && r_vld[i] && (r_val[0] < r_val[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (w_room) begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (r_cnt == CNT_W'(i)) begin
                            r_vld[i] <= 1'b1;
                        end
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.rotate) begin
                for (int i = 0; i < DEPTH - 1; i++) begin
                    r_vld[i] <= r_vld[i + 1];
                end
                r_vld[DEPTH - 1] <= r_vld[0];
            end
            if (i_cmd.emit) begin
                for (int i = 0; i < DEPTH - 1; i++) begin
                    r_vld[i] <= r_vld[i + 1];
                end
                r_vld[DEPTH - 1] <= 1'b0;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_ovf <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_room) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (r_cnt == CNT_W'(i)) begin
                    r_val[i]  <= $signed(i_value);
                    r_rank[i] <= '0;
                end
            end
        end
        if (i_cmd.rotate) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_val[i]  <= r_val[i + 1];
                r_rank[i] <= r_rank[i + 1] + RANK_W'(w_inc[i + 1]);
            end
            r_val[DEPTH - 1]  <= r_val[0];
            r_rank[DEPTH - 1] <= r_rank[0] + RANK_W'(w_inc[0]);
        end
        if (i_cmd.emit) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_val[i]  <= r_val[i + 1];
                r_rank[i] <= r_rank[i + 1];
            end
        end
    end

    assign o_stat.emit_last = (r_cnt == CNT_W'(1));
    assign o_rank           = r_rank[0];
    assign o_overflow       = r_ovf;

endmodule

FILE: design/rbv_ctrl.sv
// Controller of the rank-by-value unit: load, rank and emit phases and the
// ring step counter. Uses rbv_pkg.
module rbv_ctrl import rbv_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    input  logic  i_s_tlast,
    output logic  o_s_tready,
    output logic  o_m_tvalid,
    input  logic  i_m_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam int STEP_W = $clog2(DEPTH);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step,  n_step;
    logic              w_step_end;

    assign w_step_end = (r_step == STEP_W'(DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_LOAD: begin
                n_step = '0;
                if (i_s_tvalid && i_s_tlast) begin
                    n_state = S_RANK;
                end
            end
            S_RANK: begin
                n_step = r_step + STEP_W'(1);
                if (w_step_end) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_m_tready && i_stat.emit_last) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_LOAD: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_RANK: begin
                o_cmd.rotate = 1'b1;
            end
            S_EMIT: begin
                o_m_tvalid = 1'b1;
                o_cmd.emit = i_m_tready;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

FILE: design/rank_by_value_unit.sv
// Top level of the rank-by-value unit: controller plus cell datapath.
// Depends on rbv_pkg, rbv_ctrl and rbv_datapath.
//
// Takes signed 32-bit values, one item per cycle, until an item with tlast.
// Up to DEPTH values are kept; later items of the same run are dropped and
// the run's results carry the overflow flag. After the last item the cells
// rotate as a ring, each counting the values below its own, and then one
// result per kept value leaves in arrival order: its rank (number of kept
// values strictly smaller), tlast on the final one. No input is taken while
// ranking or emitting.
module rank_by_value_unit import rbv_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic        i_s_tlast,   // last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [5:0] rank, [7:6] zero
    output logic        o_m_tlast,   // last_res
    output logic        o_m_tuser    // [0] overflow
);

    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [RANK_W-1:0] w_rank;

    rbv_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rbv_datapath #(
        .DEPTH(DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_value    (i_s_tdata),
        .o_stat     (w_stat),
        .o_rank     (w_rank),
        .o_overflow (o_m_tuser)
    );

    assign o_m_tdata = {2'b00, w_rank};
    assign o_m_tlast = w_stat.emit_last;

endmodule
